// ===== sv/pvgt_pkg.sv =====
// Package for the proximity voice gain table: command codes, widths and the FSM state type.
// Used by the top level and the testbench; depends on nothing.
package pvgt_pkg;

    localparam int MAX_PLAYERS_DEF = 256;
    localparam int COORD_BITS_DEF  = 24;
    localparam int RANGE_W         = 24;
    localparam int VOL_W           = 16;
    localparam int LID_W           = 9;
    localparam int PID_W           = 8;
    localparam int CMD_W           = 3;

    localparam logic [CMD_W-1:0] CMD_GMUTE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LMUTE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WPOS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GAIN  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_MUTEQ = 3'd5;

    localparam logic [1:0] REG_RANGE = 2'd0;
    localparam logic [1:0] REG_VOL   = 2'd1;
    localparam logic [1:0] REG_LID   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_SRC,
        ST_RD_ME,
        ST_SQ,
        ST_SQRT,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== sv/pvgt_ram.sv =====
// Generic single-port-write, one-read synchronous RAM with registered read data.
// No dependencies.
module pvgt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/pvgt_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on nothing; used by the top level for the distance.
module pvgt_isqrt #(
    parameter int IN_W = 52
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [IN_W-1:0]     radicand,
    output logic                done,
    output logic [IN_W/2:0]     root
);
    localparam int HALF  = (IN_W + 1) / 2;
    localparam int RW    = 2 * HALF;
    localparam int CNT_W = $clog2(HALF + 1);

    logic [RW-1:0]    rem_reg, rem_next;
    logic [RW-1:0]    val_reg, val_next;
    logic [HALF-1:0]  q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [RW+1:0]    trial;
    logic [RW+1:0]    shifted;

    always_comb begin
        rem_next  = rem_reg;
        val_next  = val_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, val_reg[RW-1 -: 2]};
        trial     = shifted - {{(RW - HALF){1'b0}}, q_reg, 2'b01};
        if (start) begin
            rem_next  = '0;
            val_next  = RW'(radicand);
            q_next    = '0;
            cnt_next  = CNT_W'(HALF);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = val_reg << 2;
            if (!trial[RW+1]) begin
                rem_next = trial[RW-1:0];
                q_next   = {q_reg[HALF-2:0], 1'b1};
            end else begin
                rem_next = shifted[RW-1:0];
                q_next   = {q_reg[HALF-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        val_reg <= val_next;
        q_reg   <= q_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign root = (IN_W/2 + 1)'(q_next);
endmodule

// ===== sv/pvgt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the gain scaling.
// Depends on nothing; used by the top level.
module pvgt_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W+1:0] sh;
    logic [DEN_W+1:0] diff;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh        = {rem_reg, q_reg[NUM_W-1]};
        diff      = sh - {2'b00, d_reg};
        if (start) begin
            rem_next  = '0;
            q_next    = num;
            d_next    = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DEN_W+1]) begin
                rem_next = diff[DEN_W:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = sh[DEN_W:0];
                q_next   = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = q_next;
endmodule

// ===== sv/proximity_voice_gain_table.sv =====
// A command takes one beat in and gives exactly one result beat. After reset the mute memory is
// cleared entry by entry, with s_tready held low. A mute or position write, a clear, a mute
// query or a gain query that needs no distance passes through RD_SRC and OUT. A gain query with
// both positions known passes through RD_SRC, RD_ME, squaring, the bit-serial square root and
// MUL, then through the restoring divider (VOL+RANGE bits) unless the distance reaches the
// range, and then OUT. A new command is taken only in IDLE, once the previous result has been
// loaded for output. The two iterative units set the rate. A result waiting on m_tready stalls
// only the next result, never the processing of the next beat.
// Depends on pvgt_pkg, pvgt_ram, pvgt_isqrt and pvgt_div.
module proximity_voice_gain_table #(
    parameter int MAX_PLAYERS = pvgt_pkg::MAX_PLAYERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[2:0], player_id[10:3], mute_on[11], pos_x[35:12], pos_y[59:36], pos_z[83:60]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // gain[15:0], globally_muted[16]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    localparam int COORD_BITS = pvgt_pkg::COORD_BITS_DEF;
    localparam int AW    = $clog2(MAX_PLAYERS);
    localparam int CW    = 3 * COORD_BITS;
    localparam int DW    = COORD_BITS + 1;
    localparam int SQW   = 2 * DW;
    localparam int SUMW  = SQW + 2;
    localparam int RTW   = SUMW / 2 + 1;
    localparam int NUMW  = pvgt_pkg::VOL_W + pvgt_pkg::RANGE_W;

    logic [pvgt_pkg::RANGE_W-1:0] range_reg;
    logic [pvgt_pkg::VOL_W-1:0]   vol_reg;
    logic [pvgt_pkg::LID_W-1:0]   lid_reg;

    pvgt_pkg::state_t state_reg, state_next;

    logic [pvgt_pkg::CMD_W-1:0] cmd_reg;
    logic [pvgt_pkg::PID_W-1:0] pid_reg;
    logic                       on_reg;
    logic [CW-1:0]              pos_reg;

    logic [MAX_PLAYERS-1:0] pv_reg;

    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [CW-1:0]   src_reg;
    logic [DW-1:0]   dx_reg, dy_reg, dz_reg;
    logic [SQW-1:0]  sx_reg, sy_reg, sz_reg;
    logic [SUMW-1:0] sum_reg;
    logic [1:0]      sq_cnt_reg;
    logic [pvgt_pkg::RANGE_W-1:0] dist_reg;

    logic [15:0] gain_reg;
    logic        gmq_reg;
    logic [16:0] res_reg;
    logic        ovalid_reg;

    logic                       acc;
    logic [pvgt_pkg::CMD_W-1:0] in_cmd;
    logic [pvgt_pkg::PID_W-1:0] in_pid;
    logic                       pid_ok, lid_ok;
    logic [AW-1:0]              pa, la;
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [CW-1:0]              ram_rdata;
    logic                       mute_we;
    logic [AW-1:0]              mute_waddr;
    logic [1:0]                 mute_wdata;
    logic [1:0]                 mute_rdata;
    logic                       mute_any;
    logic                       sqrt_start, sqrt_done;
    logic [RTW-1:0]             root;
    logic                       div_start, div_done;
    logic [NUMW-1:0]            num_mul;
    logic [NUMW-1:0]            quot;
    logic                       need_dist;
    logic                       out_load;

    assign acc    = s_tvalid && s_tready;
    assign in_cmd = s_tdata[2:0];
    assign in_pid = s_tdata[10:3];
    assign pid_ok = 32'(pid_reg) < MAX_PLAYERS;
    assign lid_ok = !lid_reg[pvgt_pkg::LID_W-1] && (32'(lid_reg) < MAX_PLAYERS);
    assign pa     = AW'(pid_reg);
    assign la     = AW'(lid_reg);

    // Bit 0 of a mute word is the global mute, bit 1 the local mute.
    assign mute_any  = mute_rdata[0] || mute_rdata[1];
    assign need_dist = pid_ok && !mute_any && lid_ok && pv_reg[pa] && pv_reg[la];
    assign num_mul   = NUMW'(vol_reg) * NUMW'(range_reg - dist_reg);
    assign out_load  = (state_reg == pvgt_pkg::ST_OUT) && (!ovalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= 24'd5120;
            vol_reg   <= 16'd4096;
            lid_reg   <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pvgt_pkg::REG_RANGE: begin
                    if (cfg_wdata != '0) begin
                        range_reg <= cfg_wdata;
                    end
                end
                pvgt_pkg::REG_VOL: vol_reg <= cfg_wdata[15:0];
                pvgt_pkg::REG_LID: lid_reg <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pvgt_pkg::ST_IDLE:   if (acc) state_next = pvgt_pkg::ST_RD_SRC;
            pvgt_pkg::ST_RD_SRC: begin
                if (cmd_reg == pvgt_pkg::CMD_GAIN && need_dist) begin
                    state_next = pvgt_pkg::ST_RD_ME;
                end else begin
                    state_next = pvgt_pkg::ST_OUT;
                end
            end
            pvgt_pkg::ST_RD_ME:  state_next = pvgt_pkg::ST_SQ;
            pvgt_pkg::ST_SQ:     if (sq_cnt_reg == 2'd3) state_next = pvgt_pkg::ST_SQRT;
            pvgt_pkg::ST_SQRT:   if (sqrt_done) state_next = pvgt_pkg::ST_MUL;
            pvgt_pkg::ST_MUL:    state_next = (dist_reg >= range_reg) ? pvgt_pkg::ST_OUT
                                                                      : pvgt_pkg::ST_DIV;
            pvgt_pkg::ST_DIV:    if (div_done) state_next = pvgt_pkg::ST_OUT;
            pvgt_pkg::ST_OUT:    if (!ovalid_reg || m_tready) state_next = pvgt_pkg::ST_IDLE;
            default:             state_next = pvgt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = (state_reg == pvgt_pkg::ST_IDLE) && !clr_busy_reg;
        ram_we     = (state_reg == pvgt_pkg::ST_RD_SRC) && cmd_reg == pvgt_pkg::CMD_WPOS
                     && pid_ok;
        ram_raddr  = (state_reg == pvgt_pkg::ST_RD_SRC) ? la : pa;
        mute_we    = clr_busy_reg || ((state_reg == pvgt_pkg::ST_RD_SRC) && pid_ok
                     && (cmd_reg inside {pvgt_pkg::CMD_GMUTE, pvgt_pkg::CMD_LMUTE}));
        mute_waddr = clr_busy_reg ? clr_addr_reg : pa;
        if (clr_busy_reg) begin
            mute_wdata = 2'b00;
        end else if (cmd_reg == pvgt_pkg::CMD_GMUTE) begin
            mute_wdata = {mute_rdata[1], on_reg};
        end else begin
            mute_wdata = {on_reg, mute_rdata[0]};
        end
        sqrt_start = (state_reg == pvgt_pkg::ST_SQ) && (sq_cnt_reg == 2'd3);
        div_start  = (state_reg == pvgt_pkg::ST_MUL) && (dist_reg < range_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pvgt_pkg::ST_IDLE;
            pv_reg       <= '0;
            ovalid_reg   <= 1'b0;
            sq_cnt_reg   <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                ovalid_reg <= 1'b1;
            end else if (ovalid_reg && m_tready) begin
                ovalid_reg <= 1'b0;
            end
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MAX_PLAYERS - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (state_reg == pvgt_pkg::ST_RD_SRC) begin
                case (cmd_reg)
                    pvgt_pkg::CMD_WPOS:  if (pid_ok) pv_reg[pa] <= 1'b1;
                    pvgt_pkg::CMD_CLR:   pv_reg <= '0;
                    default: ;
                endcase
            end
            sq_cnt_reg <= (state_reg == pvgt_pkg::ST_SQ) ? sq_cnt_reg + 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg <= in_cmd;
            pid_reg <= in_pid;
            on_reg  <= s_tdata[11];
            pos_reg <= CW'(s_tdata[12 +: 72]);
        end
        if (state_reg == pvgt_pkg::ST_RD_SRC) begin
            gmq_reg <= (cmd_reg == pvgt_pkg::CMD_MUTEQ) && pid_ok && mute_rdata[0];
            if (cmd_reg == pvgt_pkg::CMD_GAIN && (!pid_ok || (!mute_any && !need_dist))) begin
                gain_reg <= vol_reg;
            end else begin
                gain_reg <= '0;
            end
        end
        if (state_reg == pvgt_pkg::ST_RD_ME) begin
            src_reg <= ram_rdata;
        end
        if (state_reg == pvgt_pkg::ST_SQ) begin
            case (sq_cnt_reg)
                2'd0: begin
                    dx_reg <= DW'($signed(src_reg[0 +: COORD_BITS]))
                              - DW'($signed(ram_rdata[0 +: COORD_BITS]));
                    dy_reg <= DW'($signed(src_reg[COORD_BITS +: COORD_BITS]))
                              - DW'($signed(ram_rdata[COORD_BITS +: COORD_BITS]));
                    dz_reg <= DW'($signed(src_reg[2*COORD_BITS +: COORD_BITS]))
                              - DW'($signed(ram_rdata[2*COORD_BITS +: COORD_BITS]));
                end
                2'd1: begin
                    sx_reg <= SQW'($signed(dx_reg) * $signed(dx_reg));
                    sy_reg <= SQW'($signed(dy_reg) * $signed(dy_reg));
                    sz_reg <= SQW'($signed(dz_reg) * $signed(dz_reg));
                end
                2'd2: sum_reg <= SUMW'(sx_reg) + SUMW'(sy_reg) + SUMW'(sz_reg);
                default: ;
            endcase
        end
        if (sqrt_done) begin
            dist_reg <= (root > RTW'(range_reg)) ? range_reg
                                                 : root[pvgt_pkg::RANGE_W-1:0];
        end
        if (state_reg == pvgt_pkg::ST_MUL) begin
            gain_reg <= '0;
        end
        if (div_done) begin
            gain_reg <= quot[15:0];
        end
        if (out_load) begin
            res_reg <= {gmq_reg, gain_reg};
        end
    end

    pvgt_ram #(.WIDTH(CW), .DEPTH(MAX_PLAYERS)) u_coord (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pa),
        .wdata (pos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pvgt_ram #(.WIDTH(2), .DEPTH(MAX_PLAYERS)) u_mute (
        .aclk  (aclk),
        .we    (mute_we),
        .waddr (mute_waddr),
        .wdata (mute_wdata),
        .raddr (AW'(in_pid)),
        .rdata (mute_rdata)
    );

    pvgt_isqrt #(.IN_W(SUMW)) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (root)
    );

    pvgt_div #(.NUM_W(NUMW), .DEN_W(pvgt_pkg::RANGE_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_mul),
        .den     (range_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'd0, res_reg};

    a_one_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid && state_reg != pvgt_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_units_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sqrt_start && div_start))
        else $error("both units started");
    a_wr_only_once: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> !ram_we)
        else $error("double coordinate write");
    a_out_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pvgt_pkg::ST_OUT && !m_tvalid) |=> m_tvalid)
        else $error("result lost");
endmodule

// ===== bench/tb_proximity_voice_gain_table.sv =====
// Testbench for proximity_voice_gain_table: random and directed commands with a built-in predictor
// of the mute tables, position store and distance gain, checked beat by beat on the result stream.
// Depends on pvgt_pkg and the block's RTL only.
module tb_proximity_voice_gain_table;

    typedef struct packed {
        logic [23:0] z;
        logic [23:0] y;
        logic [23:0] x;
        logic        on;
        logic [7:0]  pid;
        logic [2:0]  cmd;
    } command_t;

    typedef struct packed {
        logic [15:0] gain;
        logic        gmuted;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    proximity_voice_gain_table DUT (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor state.
    logic [23:0]        range_q = 24'd5120;
    logic [15:0]        volume_q = 16'd4096;
    logic signed [8:0]  listener_q = -9'sd1;
    logic               gmute_q [256];
    logic               lmute_q [256];
    logic               pvalid_q [256];
    logic signed [23:0] px_q [256], py_q [256], pz_q [256];

    command_t pending_cmds [$];
    answer_t  expected_answers [$];
    int errors = 0, accepted = 0, answered = 0, idle_cycles = 0;
    bit stim_done = 0;
    bit in_taken = 0;

    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] sq_of(logic signed [23:0] a, logic signed [23:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0) d = -d;
        return 64'(d) * 64'(d);
    endfunction

    function automatic logic [15:0] gain_of(logic [7:0] src);
        logic [7:0]  me;
        logic [63:0] dist_len, num;
        if (gmute_q[src] || lmute_q[src]) return 16'd0;
        if (listener_q < 0) return volume_q;
        me = listener_q[7:0];
        if (!pvalid_q[src] || !pvalid_q[me]) return volume_q;
        dist_len = root_of(sq_of(px_q[src], px_q[me]) + sq_of(py_q[src], py_q[me])
                           + sq_of(pz_q[src], pz_q[me]));
        if (dist_len >= 64'(range_q)) return 16'd0;
        num = 64'(volume_q) * (64'(range_q) - dist_len);
        return 16'(num / 64'(range_q));
    endfunction

    function automatic answer_t apply_command(command_t c);
        answer_t a;
        a = '0;
        case (c.cmd)
            pvgt_pkg::CMD_GMUTE: gmute_q[c.pid] = c.on;
            pvgt_pkg::CMD_LMUTE: lmute_q[c.pid] = c.on;
            pvgt_pkg::CMD_WPOS: begin
                px_q[c.pid] = c.x;
                py_q[c.pid] = c.y;
                pz_q[c.pid] = c.z;
                pvalid_q[c.pid] = 1'b1;
            end
            pvgt_pkg::CMD_CLR: for (int i = 0; i < 256; i++) pvalid_q[i] = 1'b0;
            pvgt_pkg::CMD_GAIN: a.gain = gain_of(c.pid);
            pvgt_pkg::CMD_MUTEQ: a.gmuted = gmute_q[c.pid];
            default: ;
        endcase
        return a;
    endfunction

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Driver.
    int send_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                in_taken = 0;
                void'(pending_cmds.pop_front());
                send_gap = gap_length();
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= {4'd0, pending_cmds[0].z, pending_cmds[0].y, pending_cmds[0].x,
                            pending_cmds[0].on, pending_cmds[0].pid, pending_cmds[0].cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result-side stall pattern.
    int recv_gap = 0;
    always @(negedge aclk) begin
        if (recv_gap > 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            recv_gap = gap_length();
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(apply_command(command_t'(s_tdata[83:0])));
                accepted++;
                in_taken = 1;
            end
            if (m_tvalid && m_tready) begin
                answered++;
                if (expected_answers.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (m_tdata[15:0] !== e.gain || m_tdata[16] !== e.gmuted
                        || m_tdata[23:17] !== 7'd0) begin
                        errors++;
                        if (errors <= 10)
                            $display("beat %0d: expected gain %h muted %b, got %h",
                                     answered, e.gain, e.gmuted, m_tdata);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (pending_cmds.size() == 0 && expected_answers.size() == 0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            pvgt_pkg::REG_RANGE: if (val != 0) range_q = val;
            pvgt_pkg::REG_VOL: volume_q = val[15:0];
            pvgt_pkg::REG_LID: listener_q = val[8:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_answers.size() > 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    function automatic command_t make_cmd(logic [2:0] c, logic [7:0] p, logic o,
                                          logic [23:0] x, logic [23:0] y, logic [23:0] z);
        command_t k;
        k = '{cmd: c, pid: p, on: o, x: x, y: y, z: z};
        return k;
    endfunction

    // Positions near a small cluster, so that distances fall around the audible range.
    function automatic logic [23:0] near_coord(int spread);
        return 24'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_phase(int n, int players);
        command_t k;
        int r;
        for (int i = 0; i < n; i++) begin
            k = '0;
            k.pid = 8'($urandom_range(0, players - 1));
            k.on = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 30) begin
                k.cmd = pvgt_pkg::CMD_WPOS;
                if ($urandom_range(0, 9) == 0) begin
                    k.x = 24'($urandom); k.y = 24'($urandom); k.z = 24'($urandom);
                end else begin
                    k.x = near_coord(8000); k.y = near_coord(8000); k.z = near_coord(2000);
                end
            end else if (r < 65) begin
                k.cmd = pvgt_pkg::CMD_GAIN;
                k.x = 24'($urandom); k.y = 24'($urandom); k.z = 24'($urandom);
            end else if (r < 75) k.cmd = pvgt_pkg::CMD_GMUTE;
            else if (r < 83) k.cmd = pvgt_pkg::CMD_LMUTE;
            else if (r < 92) k.cmd = pvgt_pkg::CMD_MUTEQ;
            else if (r < 95) k.cmd = pvgt_pkg::CMD_CLR;
            else k.cmd = 3'($urandom_range(6, 7));
            // Mutes are kept mostly off so that gain queries reach the distance path.
            if ((k.cmd == pvgt_pkg::CMD_GMUTE || k.cmd == pvgt_pkg::CMD_LMUTE)
                && $urandom_range(0, 2) != 0)
                k.on = 1'b0;
            pending_cmds.push_back(k);
        end
    endtask

    initial begin
        for (int i = 0; i < 256; i++) begin
            gmute_q[i] = 0; lmute_q[i] = 0; pvalid_q[i] = 0;
            px_q[i] = 0; py_q[i] = 0; pz_q[i] = 0;
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: defaults, mutes, extremes of coordinates and the unused commands.
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_WPOS, 8'd0, 1'b0,
                                        24'h800000, 24'h800000, 24'h800000));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_WPOS, 8'd255, 1'b1,
                                        24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_WPOS, 8'd1, 1'b0, 24'd256, 24'd0, 24'd0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GMUTE, 8'd255, 1'b1, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_MUTEQ, 8'd255, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd255, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GMUTE, 8'd255, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_LMUTE, 8'd1, 1'b1, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd1, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_LMUTE, 8'd1, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_MUTEQ, 8'd0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(3'd6, 8'd7, 1'b1, '1, '1, '1));
        pending_cmds.push_back(make_cmd(3'd7, 8'd7, 1'b1, '1, '1, '1));
        drain();

        // Listener set: same point, far corners, a player at (256, 0, 0), then a clear.
        write_reg(pvgt_pkg::REG_LID, 24'd0);
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd255, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd1, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd2, 1'b0, '0, '0, '0));
        drain();
        write_reg(pvgt_pkg::REG_LID, 24'd1);
        write_reg(pvgt_pkg::REG_RANGE, 24'hFFFFFF);
        write_reg(pvgt_pkg::REG_VOL, 24'h00FFFF);
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd255, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_CLR, 8'd0, 1'b0, '0, '0, '0));
        pending_cmds.push_back(make_cmd(pvgt_pkg::CMD_GAIN, 8'd0, 1'b0, '0, '0, '0));
        drain();

        // Random phases across several register settings.
        write_reg(pvgt_pkg::REG_RANGE, 24'd0);
        write_reg(pvgt_pkg::REG_LID, 24'd3);
        write_reg(pvgt_pkg::REG_RANGE, 24'd5120);
        write_reg(pvgt_pkg::REG_VOL, 24'd4096);
        random_phase(200, 8);
        drain();
        write_reg(pvgt_pkg::REG_RANGE, 24'd1);
        write_reg(pvgt_pkg::REG_VOL, 24'd0);
        random_phase(60, 8);
        drain();
        write_reg(pvgt_pkg::REG_RANGE, 24'd12000);
        write_reg(pvgt_pkg::REG_VOL, 24'h00FFFF);
        write_reg(pvgt_pkg::REG_LID, 24'd255);
        random_phase(150, 256);
        drain();
        write_reg(pvgt_pkg::REG_LID, 24'h000100);
        random_phase(60, 8);
        drain();
        write_reg(pvgt_pkg::REG_LID, 24'd5);
        write_reg(pvgt_pkg::REG_RANGE, 24'hFFFFFF);
        write_reg(pvgt_pkg::REG_VOL, 24'($urandom_range(0, 65535)));
        random_phase(230, 8);
        drain();

        $display("%0d commands accepted, %0d results checked over several range, volume and",
                 accepted, answered);
        $display("listener settings; %0d mismatches.", errors);
        if (errors == 0 && expected_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
